@@ hw/rtl/lctp_pkg.sv @@
// shared types, constants and character classes for the large-community text parser
`timescale 1ns / 1ps

package lctp_pkg;

    // default saturation limit of the character count
    localparam int MAX_LEN_DEFAULT = 255;

    // field limits and character codes
    localparam logic [31:0] FIELD_VALUE_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0]  CH_COLON        = 8'h3A;
    localparam logic [7:0]  CH_ZERO         = 8'h30;
    localparam logic [7:0]  CH_NINE         = 8'h39;
    localparam logic [7:0]  CH_SPACE        = 8'h20;
    localparam logic [7:0]  CH_TAB          = 8'h09;
    localparam logic [7:0]  CH_CR           = 8'h0D;
    localparam logic [3:0]  RADIX           = 4'd10;

    // widest value the consumed_len field holds
    localparam logic [7:0]  LEN_FIELD_MAX = 8'hFF;

    // field index codes
    localparam logic [1:0]  FIELD_GLOBAL = 2'd0;
    localparam logic [1:0]  FIELD_HIGH   = 2'd1;
    localparam logic [1:0]  FIELD_LOW    = 2'd2;

    // parse phase, one-hot
    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_DIGITS = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_FAIL   = 5'b10000
    } phase_t;

    // one result item
    typedef struct packed {
        logic [31:0] global_part;
        logic [31:0] high_local;
        logic [31:0] low_local;
        logic        parse_ok;
        logic [7:0]  consumed_len;
        logic        range_hit;
    } result_t;

    // whitespace class: tab through carriage return, and space
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // decimal digit class
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

@@ hw/rtl/lctp_core.sv @@
// parse state registers and the per-character next-state logic
`timescale 1ns / 1ps

module lctp_core #(
    parameter int MAX_LEN = lctp_pkg::MAX_LEN_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        ch,
    input  logic              last,
    output logic              res_valid,
    output lctp_pkg::result_t res
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN);

    typedef struct packed {
        lctp_pkg::phase_t phase;
        logic [1:0]       field_index;
        logic [31:0]      accumulator;
        logic             acc_overflow;
        logic [31:0]      first_value;
        logic [31:0]      second_value;
        logic [31:0]      third_value;
        logic [PW-1:0]    position;
        logic [PW-1:0]    end_position;
        logic             range_sticky;
    } pstate_t;

    localparam pstate_t PSTATE_RESET = '{
        phase:        lctp_pkg::PH_SKIP,
        field_index:  lctp_pkg::FIELD_GLOBAL,
        accumulator:  32'd0,
        acc_overflow: 1'b0,
        first_value:  32'd0,
        second_value: 32'd0,
        third_value:  32'd0,
        position:     '0,
        end_position: '0,
        range_sticky: 1'b0
    };

    // saturating character count
    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p < POS_MAX) ? p + PW'(1) : p;
    endfunction

    // write a finished field into its slot
    function automatic pstate_t store_field(input pstate_t s, input logic [31:0] v);
        pstate_t r;
        r = s;
        case (s.field_index)
            lctp_pkg::FIELD_GLOBAL: r.first_value  = v;
            lctp_pkg::FIELD_HIGH:   r.second_value = v;
            default:                r.third_value  = v;
        endcase
        return r;
    endfunction

    // a field just ended, c follows it (none marks the closing terminator)
    function automatic pstate_t after_field(input pstate_t s, input logic [7:0] c,
                                            input logic none);
        pstate_t r;
        r = s;
        if (s.field_index >= lctp_pkg::FIELD_LOW) begin
            r.end_position = s.position;
            r.phase        = lctp_pkg::PH_DONE;
        end else if (!none && (c == lctp_pkg::CH_COLON)) begin
            r.field_index = s.field_index + 2'd1;
            r.position    = bump(s.position);
            r.phase       = lctp_pkg::PH_SKIP;
        end else begin
            r.phase = lctp_pkg::PH_FAIL;
        end
        return r;
    endfunction

    // one character step of the parser
    function automatic pstate_t feed(input pstate_t s, input logic [7:0] c,
                                     input logic none);
        pstate_t     r;
        logic [3:0]  d;
        logic [35:0] v;
        r = s;
        d = c[3:0] - lctp_pkg::CH_ZERO[3:0];
        v = ({4'd0, s.accumulator} << 3) + ({4'd0, s.accumulator} << 1) + {32'd0, d};
        unique case (s.phase)
            lctp_pkg::PH_SKIP:
            begin
                if (!none && lctp_pkg::is_space(c)) begin
                    r.position = bump(s.position);
                end else if (!none && (c == lctp_pkg::CH_ZERO)) begin
                    r          = store_field(s, 32'd0);
                    r.position = bump(s.position);
                    if (s.field_index >= lctp_pkg::FIELD_LOW) begin
                        r.end_position = r.position;
                        r.phase        = lctp_pkg::PH_DONE;
                    end else begin
                        r.phase = lctp_pkg::PH_ZERO;
                    end
                end else if (!none && lctp_pkg::is_digit(c)) begin
                    r.accumulator  = {28'd0, d};
                    r.acc_overflow = 1'b0;
                    r.position     = bump(s.position);
                    r.phase        = lctp_pkg::PH_DIGITS;
                end else begin
                    r.phase = lctp_pkg::PH_FAIL;
                end
            end
            lctp_pkg::PH_DIGITS:
            begin
                if (!none && lctp_pkg::is_digit(c)) begin
                    if (!s.acc_overflow) begin
                        if (v[35:32] != 4'd0) begin
                            r.acc_overflow = 1'b1;
                            r.accumulator  = lctp_pkg::FIELD_VALUE_MAX;
                        end else begin
                            r.accumulator = v[31:0];
                        end
                    end
                    r.position = bump(s.position);
                end else begin
                    r = store_field(s, s.accumulator);
                    if (s.acc_overflow) begin
                        r.range_sticky = 1'b1;
                    end
                    r = after_field(r, c, none);
                end
            end
            lctp_pkg::PH_ZERO:
            begin
                r = after_field(s, c, none);
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

    pstate_t state_reg;
    pstate_t state_next;
    pstate_t after_char;
    pstate_t after_close;

    logic [PW+7:0] end_wide;

    // byte step, then the closing terminator step for the final byte
    always_comb
    begin
        after_char  = feed(state_reg, ch, 1'b0);
        after_close = feed(after_char, 8'd0, 1'b1);
    end

    // next state: return to reset after the final byte
    always_comb
    begin
        state_next = state_reg;
        if (accept) begin
            state_next = last ? PSTATE_RESET : after_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= PSTATE_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    // result item for the final byte
    assign end_wide  = {8'd0, after_close.end_position};
    assign res_valid = accept && last;

    always_comb
    begin
        res           = '0;
        res.range_hit = after_close.range_sticky;
        if (after_close.phase == lctp_pkg::PH_DONE) begin
            res.global_part  = after_close.first_value;
            res.high_local   = after_close.second_value;
            res.low_local    = after_close.third_value;
            res.parse_ok     = 1'b1;
            res.consumed_len = (end_wide > (PW+8)'(lctp_pkg::LEN_FIELD_MAX))
                             ? lctp_pkg::LEN_FIELD_MAX : end_wide[7:0];
        end
    end

endmodule

@@ hw/rtl/lctp_out_buf.sv @@
// two-entry result buffer between the parser and the result channel
`timescale 1ns / 1ps

module lctp_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  lctp_pkg::result_t wr_data,
    output logic              full,
    output logic              rd_valid,
    input  logic              rd_stall,
    output lctp_pkg::result_t rd_data
);

    lctp_pkg::result_t entry_reg [2];

    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign pop      = rd_valid && !rd_stall;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/large_community_text_parser.sv @@
// top level of the large-community text parser
`timescale 1ns / 1ps

// Parses "global:high:low" large-community text, one byte per item.
// Character channel: char_valid/char_stall carry ch and last; last marks the
// final byte of a string. Result channel: result_valid/result_stall carry the
// three values, parse_ok, consumed_len and range_hit, one item per string.
// Throughput: one character item per cycle while char_stall is low; the parse state updates in the
// same cycle the byte is taken, through the digit multiply-add and phase logic.
// The result item is written into the result buffer when the item with last=1
// is accepted, and shows on the result channel behind any earlier result.
// A two-entry result buffer sits between the parser and the result channel, so
// characters keep flowing while a result waits. char_stall rises whenever
// both entries are full, also when the receiver takes one in that cycle.
// Reset clears the parse state and empties the result buffer; no clearing
// pass, the block takes items from the first cycle after reset.
// Failed strings give zero values, parse_ok 0 and consumed_len 0.

module large_community_text_parser #(
    parameter int MAX_LEN = lctp_pkg::MAX_LEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] global_part,
    output logic [31:0] high_local,
    output logic [31:0] low_local,
    output logic        parse_ok,
    output logic [7:0]  consumed_len,
    output logic        range_hit
);

    logic              accept;
    logic              res_valid;
    logic              buf_full;
    lctp_pkg::result_t res;
    lctp_pkg::result_t out_item;

    // input handshake
    assign char_stall = buf_full;
    assign accept     = char_valid && !char_stall;

    // parser
    lctp_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (ch),
        .last      (last),
        .res_valid (res_valid),
        .res       (res)
    );

    // result buffer
    lctp_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_valid),
        .wr_data  (res),
        .full     (buf_full),
        .rd_valid (result_valid),
        .rd_stall (result_stall),
        .rd_data  (out_item)
    );

    // result fields
    assign global_part  = out_item.global_part;
    assign high_local   = out_item.high_local;
    assign low_local    = out_item.low_local;
    assign parse_ok     = out_item.parse_ok;
    assign consumed_len = out_item.consumed_len;
    assign range_hit    = out_item.range_hit;

endmodule

@@ hw/rtl/lctp_checker.sv @@
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps

module lctp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] global_part,
    input logic [31:0] high_local,
    input logic [31:0] low_local,
    input logic        parse_ok,
    input logic [7:0]  consumed_len
);

    // a stalled result item stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result item dropped while stalled");

    // a stalled result item holds its global part, low local value and length
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(global_part) && $stable(low_local)
            && $stable(consumed_len))
        else $error("result item changed while stalled");

    // a failed parse reports zero values and zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !parse_ok |-> global_part == 32'd0 && high_local == 32'd0
            && low_local == 32'd0 && consumed_len == 8'd0)
        else $error("failed parse with nonzero fields");

    // a good parse covers at least the shortest text, three zeros and two colons
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && parse_ok |-> consumed_len >= 8'd5)
        else $error("good parse with too short a length");

endmodule

bind large_community_text_parser lctp_checker u_lctp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .global_part  (global_part),
    .high_local   (high_local),
    .low_local    (low_local),
    .parse_ok     (parse_ok),
    .consumed_len (consumed_len)
);
